[rtl/core/dwc3_pkg.sv]
`default_nettype none

package dwc3_pkg;

    localparam int unsigned DEFAULT_MAX_WIDTH = 2048;
    localparam int unsigned SAMPLE_BITS       = 16;
    localparam int unsigned WEIGHT_BITS       = 16;
    localparam int unsigned TAPS              = 9;
    localparam int unsigned DIM_W             = 12;
    localparam int unsigned HEIGHT_LIMIT      = 2048;
    localparam int unsigned ROW_W             = $clog2(HEIGHT_LIMIT);
    localparam int unsigned FRAC_SHIFT        = 14;
    localparam int unsigned PROD_W            = SAMPLE_BITS + WEIGHT_BITS;
    localparam int unsigned ACC_W             = PROD_W + 4;
    localparam int unsigned SHIFT_W           = ACC_W - FRAC_SHIFT;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [SHIFT_W-1:0] shifted_t;
    typedef logic [TAPS-1:0][SAMPLE_BITS-1:0] taps_t;
    typedef logic [TAPS-1:0][WEIGHT_BITS-1:0] weights_t;

    localparam acc_t     ROUND_HALF = acc_t'(2 ** (FRAC_SHIFT - 1));
    localparam shifted_t SAT_HI     = shifted_t'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam shifted_t SAT_LO     = shifted_t'(-(2 ** (SAMPLE_BITS - 1)));

    typedef struct packed {
        logic  valid;
        logic  last;
        taps_t taps;
    } win_item_t;

    typedef struct packed {
        logic  valid;
        logic  last;
        taps_t taps;
        acc_t  acc;
    } cell_data_t;

endpackage

`default_nettype wire

[rtl/core/dwc3_line_buffer.sv]
`default_nettype none

module dwc3_line_buffer #(
    parameter int unsigned MAX_WIDTH = dwc3_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  dwc3_pkg::sample_t             pixel,
    input  logic                          restart,
    input  logic [dwc3_pkg::DIM_W-1:0]    plane_width,
    input  logic [dwc3_pkg::DIM_W-1:0]    plane_height,
    input  logic                          stride_two,
    output dwc3_pkg::win_item_t           item
);
    import dwc3_pkg::*;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CMP_W = (WID_W > DIM_W) ? WID_W : DIM_W;

    logic [CMP_W-1:0]         width_ext;
    logic [WID_W-1:0]         width_eff;
    logic [DIM_W-1:0]         height_eff;
    logic [COL_W-1:0]         col_last;
    logic [ROW_W-1:0]         row_last;
    logic [COL_W-1:0]         col_stop;
    logic [ROW_W-1:0]         row_stop;
    logic [COL_W-1:0]         col_reg;
    logic [COL_W-1:0]         col_next;
    logic [ROW_W-1:0]         row_reg;
    logic [ROW_W-1:0]         row_next;
    logic [2*SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*SAMPLE_BITS-1:0] rd_word_reg;
    logic [2*SAMPLE_BITS-1:0] wr_word;
    logic [SAMPLE_BITS-1:0]   above2;
    logic [SAMPLE_BITS-1:0]   above1;
    taps_t                    win_reg;
    taps_t                    win_next;

    always_comb
    begin
        width_ext = CMP_W'(plane_width);
        if (width_ext < CMP_W'(3))
        begin
            width_eff = WID_W'(3);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            width_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WID_W'(width_ext);
        end
        if (plane_height < DIM_W'(3))
        begin
            height_eff = DIM_W'(3);
        end
        else if (plane_height > DIM_W'(HEIGHT_LIMIT))
        begin
            height_eff = DIM_W'(HEIGHT_LIMIT);
        end
        else
        begin
            height_eff = plane_height;
        end
        col_last = COL_W'(width_eff - WID_W'(1));
        row_last = ROW_W'(height_eff - DIM_W'(1));
        col_stop = stride_two ? {col_last[COL_W-1:1], 1'b0} : col_last;
        row_stop = stride_two ? {row_last[ROW_W-1:1], 1'b0} : row_last;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == col_last)
            begin
                col_next = '0;
                row_next = (row_reg == row_last) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Each column word holds the two rows above; the next column is read ahead.
    assign above2  = rd_word_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign above1  = rd_word_reg[SAMPLE_BITS-1:0];
    assign wr_word = {above1, pixel};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_reg] <= wr_word;
        end
        rd_word_reg <= line_mem[col_next];
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r * 3]     = win_reg[r * 3 + 1];
            win_next[r * 3 + 1] = win_reg[r * 3 + 2];
        end
        win_next[2] = above2;
        win_next[5] = above1;
        win_next[8] = pixel;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        item.valid = accept && (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2))
                     && (!stride_two || (!row_reg[0] && !col_reg[0]));
        item.last  = (row_reg == row_stop) && (col_reg == col_stop);
        item.taps  = win_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) col_reg <= col_last)
        else $error("Column position is outside the plane width.");
    assert property (@(posedge clk) disable iff (!rst_n) row_reg <= row_last)
        else $error("Row position is outside the plane height.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last) |-> item.valid)
        else $error("The last window position of a plane gives no item.");
`endif

endmodule

`default_nettype wire

[rtl/core/dwc3_mac_cell.sv]
`default_nettype none

module dwc3_mac_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dwc3_pkg::cell_data_t in_data,
    input  dwc3_pkg::sample_t    tap,
    input  dwc3_pkg::weight_t    weight,
    input  logic                 ready_down,
    output logic                 ready_up,
    output dwc3_pkg::cell_data_t out_data
);
    import dwc3_pkg::*;

    logic signed [PROD_W-1:0] product;
    cell_data_t               data_next;
    cell_data_t               data_reg;
    logic                     valid_reg;

    assign ready_up = !valid_reg || ready_down;

    always_comb
    begin
        product       = tap * weight;
        data_next     = in_data;
        data_next.acc = in_data.acc + acc_t'(product);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= in_data.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && in_data.valid)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        out_data       = data_reg;
        out_data.valid = valid_reg;
    end

endmodule

`default_nettype wire

[rtl/core/depthwise_conv3x3_stream_top.sv]
`default_nettype none

// Streaming 3x3 depthwise convolution of one bordered Q8.8 plane, fed in raster order.
// The block takes one pixel per clock while the output side does not stall it; a
// result passes from the window through nine multiply-accumulate cells and then one
// output register (the window feeds the first cell directly at the edge that accepts
// the pixel completing it). The line store is a MAX_WIDTH by 32-bit memory with one
// write and one look-ahead read per cycle; each row is written before it is read, so
// it needs no clearing after reset. Weights and bias may be changed between planes;
// writing plane_width, plane_height or stride_two restarts the plane. Registers are
// to be written only while the block is idle; the block itself does not enforce
// this. The last result of a plane carries tlast.
module depthwise_conv3x3_stream_top #(
    parameter int unsigned MAX_WIDTH = dwc3_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pixel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] result_value
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import dwc3_pkg::*;

    typedef enum logic [2:0] {
        REG_KERNEL_TOP,
        REG_KERNEL_MID,
        REG_KERNEL_BOT,
        REG_BIAS_VALUE,
        REG_PLANE_WIDTH,
        REG_PLANE_HEIGHT,
        REG_STRIDE_TWO
    } cfg_reg_t;

    cfg_reg_t             cfg_index;
    logic                 cfg_write;
    logic                 restart;
    logic [47:0]          kernel_row_top_reg;
    logic [47:0]          kernel_row_mid_reg;
    logic [47:0]          kernel_row_bot_reg;
    sample_t              bias_value_reg;
    logic [DIM_W-1:0]     plane_width_reg;
    logic [DIM_W-1:0]     plane_height_reg;
    logic                 stride_two_reg;
    weights_t             weights;
    logic                 accept;
    win_item_t            item;
    cell_data_t           chain [TAPS+1];
    logic [TAPS:0]        ready;
    logic [TAPS-1:0]      cell_valid;
    shifted_t             shifted;
    sample_t              saturated;
    logic                 out_valid_reg;
    sample_t              out_value_reg;
    logic                 out_last_reg;

    assign pready    = 1'b1;
    assign cfg_index = cfg_reg_t'(paddr[5:3]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign restart   = cfg_write && (cfg_index == REG_PLANE_WIDTH
                       || cfg_index == REG_PLANE_HEIGHT || cfg_index == REG_STRIDE_TWO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_row_top_reg <= '0;
            kernel_row_mid_reg <= '0;
            kernel_row_bot_reg <= '0;
            bias_value_reg     <= '0;
            plane_width_reg    <= DIM_W'(3);
            plane_height_reg   <= DIM_W'(3);
            stride_two_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KERNEL_TOP:   kernel_row_top_reg <= pwdata[47:0];
                REG_KERNEL_MID:   kernel_row_mid_reg <= pwdata[47:0];
                REG_KERNEL_BOT:   kernel_row_bot_reg <= pwdata[47:0];
                REG_BIAS_VALUE:   bias_value_reg     <= pwdata[SAMPLE_BITS-1:0];
                REG_PLANE_WIDTH:  plane_width_reg    <= pwdata[DIM_W-1:0];
                REG_PLANE_HEIGHT: plane_height_reg   <= pwdata[DIM_W-1:0];
                REG_STRIDE_TWO:   stride_two_reg     <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_KERNEL_TOP:   prdata = 64'(kernel_row_top_reg);
            REG_KERNEL_MID:   prdata = 64'(kernel_row_mid_reg);
            REG_KERNEL_BOT:   prdata = 64'(kernel_row_bot_reg);
            REG_BIAS_VALUE:   prdata = 64'(unsigned'(bias_value_reg));
            REG_PLANE_WIDTH:  prdata = 64'(plane_width_reg);
            REG_PLANE_HEIGHT: prdata = 64'(plane_height_reg);
            REG_STRIDE_TWO:   prdata = 64'(stride_two_reg);
            default:          prdata = '0;
        endcase
    end

    assign weights = {kernel_row_bot_reg, kernel_row_mid_reg, kernel_row_top_reg};

    assign s_axis_tready = ready[0];
    assign accept        = s_axis_tvalid && s_axis_tready;

    dwc3_line_buffer #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_line_buffer (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .pixel       (s_axis_tdata),
        .restart     (restart),
        .plane_width (plane_width_reg),
        .plane_height(plane_height_reg),
        .stride_two  (stride_two_reg),
        .item        (item)
    );

    always_comb
    begin
        chain[0].valid = item.valid;
        chain[0].last  = item.last;
        chain[0].taps  = item.taps;
        chain[0].acc   = (acc_t'(bias_value_reg) <<< FRAC_SHIFT) + ROUND_HALF;
    end

    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        dwc3_mac_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_data   (chain[k]),
            .tap       (chain[k].taps[k]),
            .weight    (weights[k]),
            .ready_down(ready[k+1]),
            .ready_up  (ready[k]),
            .out_data  (chain[k+1])
        );
        assign cell_valid[k] = chain[k+1].valid;
    end

    always_comb
    begin
        shifted = chain[TAPS].acc[ACC_W-1:FRAC_SHIFT];
        if (shifted > SAT_HI)
        begin
            saturated = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            saturated = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            saturated = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign ready[TAPS] = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ready[TAPS])
        begin
            out_valid_reg <= chain[TAPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[TAPS] && chain[TAPS].valid)
        begin
            out_value_reg <= saturated;
            out_last_reg  <= chain[TAPS].last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> ((&cell_valid) && out_valid_reg && !m_axis_tready))
        else $error("Input stalled while the cell chain has a free stage.");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cell_valid[TAPS-1]))
        else $error("Output became valid without an item from the last cell.");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(ready[TAPS]))
        else $error("Output register loaded while it was full and stalled.");
`endif

endmodule

`default_nettype wire
